### rtl/core/ebd_pkg.sv
// Shared types and constants of the energy beat detector.
`default_nettype none

package ebd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WORD_W    = 16;
  localparam int ENERGY_W  = 43;
  localparam int WLEN_W    = 13;
  localparam int THR_W     = 8;
  localparam int COUNT_W   = 12;
  localparam int MAG_W     = 17;
  localparam int SQ_W      = 31;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 13;

  localparam logic [WLEN_W-1:0] MAX_WINDOW   = 13'd4096;
  localparam logic [WLEN_W-1:0] WLEN_RESET   = 13'd800;
  localparam logic [THR_W-1:0]  THR_RESET    = 8'd13;
  localparam int                HISTORY_DEPTH_DEFAULT = 20;

  // Depth of the window queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 1'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [WORD_W-1:0]          random_word;
  } in_item_t;

  typedef struct packed {
    logic                beat;
    logic [WORD_W-1:0]   pattern;
    logic [ENERGY_W-1:0] window_energy;
  } out_item_t;

  // One finished window travelling from front to back.
  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [WORD_W-1:0]   random_word;
  } window_t;

endpackage

`default_nettype wire

### rtl/core/ebd_front.sv
// Front end: squares samples, accumulates window energy and emits finished windows.
`default_nettype none

module ebd_front
  import ebd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [WLEN_W-1:0] window_length,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_item,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output window_t                push_data
);

  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [WLEN_W-1:0]   count_plus;
  logic [WLEN_W-1:0]   len;
  logic                last;
  logic [MAG_W-1:0]    mag;
  logic [2*MAG_W-1:0]  sq_full;
  logic                accept;

  logic                s1_valid;
  logic                s1_last;
  logic [SQ_W-1:0]     s1_sq;
  logic [WORD_W-1:0]   s1_word;
  logic                s1_go;

  logic [ENERGY_W-1:0] acc;
  logic [ENERGY_W-1:0] acc_sum;

  always_comb begin
    if (window_length == '0) begin
      len = WLEN_W'(1);
    end else if (window_length > MAX_WINDOW) begin
      len = MAX_WINDOW;
    end else begin
      len = window_length;
    end
  end

  assign count_plus = WLEN_W'(count) + WLEN_W'(1);
  assign last       = (count_plus >= len);
  assign count_next = last ? '0 : count_plus[COUNT_W-1:0];

  assign mag     = in_item.sample[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(in_item.sample))
                                              : MAG_W'(in_item.sample);
  assign sq_full = mag * mag;

  // A sample that does not close a window only updates the accumulator.
  assign s1_go    = !s1_last || push_ready;
  assign in_ready = !s1_valid || s1_go;
  assign accept   = in_valid && in_ready;

  assign acc_sum = acc + ENERGY_W'(s1_sq);

  assign push_valid            = s1_valid && s1_last;
  assign push_data.energy      = acc_sum;
  assign push_data.random_word = s1_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
      acc      <= '0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (in_ready) begin
        s1_valid <= accept;
      end
      if (s1_valid && s1_go) begin
        acc <= s1_last ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= last;
      s1_sq   <= sq_full[SQ_W-1:0];
      s1_word <= in_item.random_word;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ebd_queue.sv
// Small queue of finished windows between the front and the back end.
`default_nettype none

module ebd_queue
  import ebd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire window_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output window_t      pop_data
);

  window_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  head;
  logic [QPTR_W-1:0]  tail;
  logic [QPTR_W:0]    fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : tail + QPTR_W'(1);
      end
      if (do_pop) begin
        head <= (head == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : head + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ebd_back.sv
// Back end: history ring, running sum, threshold compare and result register.
`default_nettype none

module ebd_back
  import ebd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [THR_W-1:0] threshold_tenths,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire window_t          pop_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  localparam int SLOT_W   = $clog2(HISTORY_DEPTH);
  localparam int SUM_W    = ENERGY_W + $clog2(HISTORY_DEPTH);
  localparam int HIST_MUL = HISTORY_DEPTH * 10;
  localparam int LHS_W    = ENERGY_W + $clog2(HIST_MUL + 1);
  localparam int RHS_W    = THR_W + SUM_W;
  localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  logic [ENERGY_W-1:0]      ring [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] ring_ok;
  logic [ENERGY_W-1:0]      old_rd;
  logic                     old_ok;
  logic [ENERGY_W-1:0]      old_energy;

  logic [SLOT_W-1:0]        slot;
  logic [SLOT_W-1:0]        slot_next;
  logic [SUM_W-1:0]         sum;

  logic                     adv;
  logic                     pop;

  logic                     p1_valid;
  logic [ENERGY_W-1:0]      p1_energy;
  logic [SUM_W-1:0]         p1_sum;
  logic [WORD_W-1:0]        p1_word;

  logic                     p2_valid;
  logic [CMP_W-1:0]         p2_lhs;
  logic [CMP_W-1:0]         p2_rhs;
  logic [ENERGY_W-1:0]      p2_energy;
  logic [WORD_W-1:0]        p2_word;

  logic                     beat;

  assign adv       = !out_valid || out_ready;
  assign pop       = adv && pop_valid;
  assign pop_ready = adv;

  always_comb begin
    slot_next = slot;
    if (pop) begin
      slot_next = (slot == SLOT_W'(HISTORY_DEPTH-1)) ? '0 : slot + SLOT_W'(1);
    end
  end

  // The oldest entry is read into a register ahead of its use; a never-written entry counts as zero.
  assign old_energy = old_ok ? old_rd : '0;

  always_ff @(posedge clk) begin
    old_rd <= ring[slot_next];
    if (pop) begin
      ring[slot] <= pop_data.energy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_ok <= '0;
      old_ok  <= 1'b0;
      slot    <= '0;
      sum     <= '0;
    end else begin
      old_ok <= ring_ok[slot_next];
      slot   <= slot_next;
      if (pop) begin
        ring_ok[slot] <= 1'b1;
        sum           <= sum - SUM_W'(old_energy) + SUM_W'(pop_data.energy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_valid  <= pop;
      p2_valid  <= p1_valid;
      out_valid <= p2_valid;
    end
  end

  assign beat = (p2_lhs > p2_rhs);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_energy <= pop_data.energy;
      p1_sum    <= sum;
      p1_word   <= pop_data.random_word;

      p2_lhs    <= CMP_W'(p1_energy) * CMP_W'(HIST_MUL);
      p2_rhs    <= CMP_W'(threshold_tenths) * CMP_W'(p1_sum);
      p2_energy <= p1_energy;
      p2_word   <= p1_word;

      out_item.beat          <= beat;
      out_item.pattern       <= beat ? p2_word : '0;
      out_item.window_energy <= p2_energy;
    end
  end

endmodule

`default_nettype wire

### rtl/core/energy_beat_detector.sv
// Top level of the energy beat detector: configuration registers and block wiring.
`default_nettype none

// The detector takes one signed audio sample per transaction on the input
// channel and adds its square to the energy of the current window. When
// window_length samples have been summed (zero counts as one, values above
// 4096 count as 4096), the window ends and exactly one transaction leaves on
// the output channel; other samples give none. A window beats when its energy
// times HISTORY_DEPTH times ten exceeds threshold_tenths times the sum of the
// previous HISTORY_DEPTH window energies; on a beat the pattern is the random
// word of the sample that closed the window, otherwise zero. The history
// starts all zero after reset, so early windows beat easily. The block takes
// one sample per clock cycle and can deliver one result per clock cycle, even
// when every sample closes a window, while the output is not stalled. Without
// stalls, a closing sample passes the s1 register, the queue, the p1 and p2
// stages and the output register. A four-entry queue separates the front end
// from the compare pipeline, so a stalled output only stalls the input once
// that queue is full. Configuration writes take effect at the next edge and
// are meant for an idle block.

module energy_beat_detector
  import ebd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item
);

  logic [WLEN_W-1:0] window_length;
  logic [THR_W-1:0]  threshold_tenths;

  logic    push_valid;
  logic    push_ready;
  window_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  window_t pop_data;

  // Both register indexes are decoded; a write simply replaces the value.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= WLEN_RESET;
      threshold_tenths <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length    <= cfg_data[WLEN_W-1:0];
        REG_THRESHOLD:     threshold_tenths <= cfg_data[THR_W-1:0];
        default:           window_length    <= window_length;
      endcase
    end
  end

  // Front end: squaring, accumulation and window counting.
  ebd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .window_length (window_length),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Finished windows wait here until the back end takes them.
  ebd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: history ring, running sum, compare and output register.
  ebd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .threshold_tenths (threshold_tenths),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item)
  );

endmodule

`default_nettype wire
